### rtl/hhfe_pkg.sv
// shared types, constants and the header name table for the header field extractor
package hhfe_pkg;

  localparam int WIN_DEPTH  = 21;
  localparam int NUM_FIELDS = 23;
  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

  localparam logic [7:0] CR_BYTE = 8'h0d;

  typedef enum logic [1:0] {
    PH_SEARCH  = 2'd0,
    PH_CAPTURE = 2'd1,
    PH_DONE    = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    KIND_VALUE  = 2'd0,
    KIND_FOUND  = 2'd1,
    KIND_ABSENT = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  vbyte;
    logic [9:0]  vlen;
    logic        is_final;
  } result_t;

  typedef struct packed {
    logic [1:0] n;
    result_t    item0;
    result_t    item1;
  } push_t;

  // last character in the low byte, unused upper bytes are zero
  localparam logic [8*WIN_DEPTH-1:0] FIELD_NAMES [NUM_FIELDS] = '{
    "Accept: ",
    "Accept-Charset: ",
    "Accept-Encoding: ",
    "Accept-Language: ",
    "Authorization: ",
    "Expect: ",
    "From: ",
    "Host: ",
    "If-Match: ",
    "If-Modified-Since: ",
    "If-None-Match: ",
    "If-Range: ",
    "If-Unmodified-Since: ",
    "Max-Forwards: ",
    "Proxy-Authorization: ",
    "Range: ",
    "Referer: ",
    "TE: ",
    "User-Agent: ",
    "Connection: ",
    "Cache-Control: ",
    "Content-Length: ",
    "Content-Range: "
  };

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5a) begin
      r = c + 8'd32;
    end
    return r;
  endfunction

endpackage

### rtl/hhfe_core.sv
// byte window, name compare, capture state and result generation
module hhfe_core
  import hhfe_pkg::*;
#(
  parameter int MAX_VALUE_LEN = 1023
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_sel,
  output push_t       push
);

  localparam int CAP_INT = (MAX_VALUE_LEN < 1023) ? MAX_VALUE_LEN : 1023;
  localparam logic [9:0] LEN_CAP = 10'(CAP_INT);

  logic [7:0]  win_r [WIN_DEPTH];
  logic [7:0]  win_nxt [WIN_DEPTH];
  phase_t      phase_r, phase_nxt;
  logic [9:0]  count_r, count_nxt;
  logic [4:0]  sel_r;

  logic [8*WIN_DEPTH-1:0] pat;
  logic        sel_ok;
  logic        match;
  logic        is_cr;
  logic        val_emit;
  logic [9:0]  count_inc;
  logic [9:0]  count_after;
  logic        found;
  result_t     val_item, stat_item;

  always_comb begin
    win_nxt[0] = data_byte;
    for (int i = 1; i < WIN_DEPTH; i++) begin
      win_nxt[i] = win_r[i-1];
    end
  end

  assign sel_ok = (sel_r < 5'(NUM_FIELDS));
  assign pat    = sel_ok ? FIELD_NAMES[sel_r] : '0;

  always_comb begin
    match = sel_ok;
    for (int i = 0; i < WIN_DEPTH; i++) begin
      if (pat[8*i +: 8] != 8'h00 &&
          fold_case(win_nxt[i]) != fold_case(pat[8*i +: 8])) begin
        match = 1'b0;
      end
    end
  end

  assign is_cr       = (data_byte == CR_BYTE);
  assign val_emit    = (phase_r == PH_CAPTURE) && !is_cr;
  assign count_inc   = (count_r < LEN_CAP) ? count_r + 10'd1 : count_r;
  assign count_after = val_emit ? count_inc : count_r;
  assign found       = (count_after != 10'd0);

  always_comb begin
    val_item.kind      = KIND_VALUE;
    val_item.vbyte     = data_byte;
    val_item.vlen      = count_inc;
    val_item.is_final  = 1'b0;
    stat_item.kind     = found ? KIND_FOUND : KIND_ABSENT;
    stat_item.vbyte    = 8'h00;
    stat_item.vlen     = found ? count_after : 10'd0;
    stat_item.is_final = 1'b1;
  end

  always_comb begin
    push.item0 = val_emit ? val_item : stat_item;
    push.item1 = stat_item;
    if (!accept) begin
      push.n = 2'd0;
    end else if (val_emit) begin
      push.n = last_byte ? 2'd2 : 2'd1;
    end else begin
      push.n = last_byte ? 2'd1 : 2'd0;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_after;
    unique case (phase_r)
      PH_SEARCH: begin
        if (match) begin
          phase_nxt = PH_CAPTURE;
        end
      end
      PH_CAPTURE: begin
        if (is_cr) begin
          phase_nxt = PH_DONE;
        end
      end
      default: begin
        phase_nxt = PH_DONE;
      end
    endcase
    if (last_byte) begin
      phase_nxt = PH_SEARCH;
      count_nxt = 10'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SEARCH;
      count_r <= 10'd0;
      for (int i = 0; i < WIN_DEPTH; i++) begin
        win_r[i] <= 8'h00;
      end
    end else if (accept) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      for (int i = 0; i < WIN_DEPTH; i++) begin
        win_r[i] <= last_byte ? 8'h00 : win_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= 5'd0;
    end else if (cfg_we) begin
      sel_r <= cfg_sel;
    end
  end

endmodule

### rtl/hhfe_out_queue.sv
// small result queue taking up to two results per cycle and giving one while out_ready is high
module hhfe_out_queue
  import hhfe_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  push_t   push,
  output logic    space_ok,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_item
);

  result_t              mem [Q_DEPTH];
  logic [Q_PTR_W-1:0]   head_r, head_nxt;
  logic [Q_PTR_W-1:0]   tail_r, tail_nxt;
  logic [Q_CNT_W-1:0]   count_r, count_nxt;
  logic                 pop;

  assign out_valid = (count_r != '0);
  assign out_item  = mem[head_r];
  assign space_ok  = (count_r <= Q_CNT_W'(Q_DEPTH - 2));
  assign pop       = out_valid && out_ready;

  always_comb begin
    head_nxt  = pop ? head_r + 1'b1 : head_r;
    tail_nxt  = tail_r + Q_PTR_W'(push.n);
    count_nxt = count_r + Q_CNT_W'(push.n) - Q_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem[tail_r] <= push.item0;
    end
    if (push.n == 2'd2) begin
      mem[tail_r + 1'b1] <= push.item1;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= Q_CNT_W'(Q_DEPTH))
    else $error("result queue count beyond depth");

  a_push_space: assert property (@(posedge clk) disable iff (!rst_n)
    (push.n != 2'd0) |-> space_ok)
    else $error("results pushed without room");

  a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && push.n == 2'd0) |=> (count_r == $past(count_r) - 1'b1))
    else $error("queue count not reduced on pop");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (tail_r - head_r) == Q_PTR_W'(count_r))
    else $error("queue pointers disagree with count");

endmodule

### rtl/http_header_field_extractor_top.sv
// top level of the http header field value extractor
//
// in_*: one request byte per transfer, in_tlast on the final byte of a request.
// cfg_*: write of field_select (0..22 name a field, higher values match none), taken whenever cfg_valid is high.
// out_*: result items; a value byte per captured byte of the selected header
//   field value (up to the first CR), and one status item with out_tlast set
//   after the final request byte: found with the value length, or absent.
// results are written into the result queue as their byte is accepted and are offered from its head in order.
// throughput: one byte per cycle while in_tready is high; the final byte of a request may yield two
//   results, which drain one at a time from a four-entry result queue.
// in_tready is high while the queue has room for two results, so a stalled
//   receiver backs up the input only once the queue holds three or more.
// reset: window, capture state and queue are cleared; field_select is 0.
// every request starts with a cleared window; field_select is kept.
module http_header_field_extractor_top
  import hhfe_pkg::*;
#(
  parameter int MAX_VALUE_LEN = 1023
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte[7:0]
  input  logic        in_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // value_byte[7:0], value_length[17:8], zero pad
  output logic [1:0]  out_tuser,  // item_kind[1:0]
  output logic        out_tlast
);

  push_t   push;
  result_t out_item;
  logic    space_ok;
  logic    accept;

  assign in_tready = space_ok;
  assign cfg_ready = 1'b1;
  assign accept    = in_tvalid && space_ok;

  hhfe_core #(
    .MAX_VALUE_LEN(MAX_VALUE_LEN)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .data_byte (in_tdata),
    .last_byte (in_tlast),
    .cfg_we    (cfg_valid),
    .cfg_sel   (cfg_data),
    .push      (push)
  );

  hhfe_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .space_ok  (space_ok),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_item  (out_item)
  );

  assign out_tdata = {6'b0, out_item.vlen, out_item.vbyte};
  assign out_tuser = out_item.kind;
  assign out_tlast = out_item.is_final;

endmodule
